/* sv/bmhq_pkg.sv */
// -----------------------------------------------------------------------------
// bmhq_pkg: shared types and codes for the binary max-heap queue
// Holds the opcode and status codes and the payload types that the channel
// interfaces, the heap queue and its checker all use.
// -----------------------------------------------------------------------------
package bmhq_pkg;

   typedef logic               opcode_type;
   typedef logic signed [31:0] value_type;
   typedef logic [1:0]         status_type;

   localparam opcode_type OP_INSERT = 1'b0;
   localparam opcode_type OP_DELETE = 1'b1;

   localparam status_type ST_DONE  = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

endpackage

/* sv/bmhq_req_if.sv */
// -----------------------------------------------------------------------------
// bmhq_req_if: request channel of the heap queue
// Valid/ready channel that carries one operation and its value.
// -----------------------------------------------------------------------------
interface bmhq_req_if;
   import bmhq_pkg::*;

   logic       valid;
   logic       ready;
   opcode_type opcode;
   value_type  value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);

endinterface

/* sv/bmhq_rsp_if.sv */
// -----------------------------------------------------------------------------
// bmhq_rsp_if: response channel of the heap queue
// Valid/ready channel that carries the status, the removed maximum, the new
// maximum and the entry count of one operation.
// -----------------------------------------------------------------------------
interface bmhq_rsp_if #(
   parameter int CNT_W = 11
);
   import bmhq_pkg::*;

   logic             valid;
   logic             ready;
   status_type       status;
   value_type        removed_value;
   value_type        top_value;
   logic [CNT_W-1:0] entry_count;

   modport source (output valid, output status, output removed_value,
                   output top_value, output entry_count, input ready);
   modport sink   (input valid, input status, input removed_value,
                   input top_value, input entry_count, output ready);

endinterface

/* sv/bmhq_ram.sv */
// -----------------------------------------------------------------------------
// bmhq_ram: generic storage array
// One write port and two read ports, with registered read data.
// -----------------------------------------------------------------------------
module bmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

/* sv/binary_max_heap_queue.sv */
// -----------------------------------------------------------------------------
// binary_max_heap_queue: priority queue kept as a binary max-heap
// Sequence: an insert climbs through S_UP_CHK and S_UP_CMP for each level
// until it reaches the root or a parent that is not smaller; a delete loads
// the last entry in S_DN_LOAD and sinks it through S_DN_CHK, S_DN_SEL and
// S_DN_CMP for each level. Flagged operations and removing the last entry go
// straight to S_FINISH. The time taken is set by the walk through the
// single storage array and the one shared comparator.
// Throughput: one transaction at a time; the next request is taken once the
// sequencer is back in idle, even while the last response still waits.
// Reset: synchronous, clears the entry count, sequencer and response valid.
// -----------------------------------------------------------------------------
module binary_max_heap_queue #(
   parameter int CAPACITY = 1024
) (
   input  logic      clock,
   input  logic      reset,
   bmhq_req_if.sink  req_chan,
   bmhq_rsp_if.source rsp_chan
);
   import bmhq_pkg::*;

   // Entry positions are 1-based, as in the textbook heap: the parent of p
   // is p/2 and its children are 2p and 2p+1. Position p lives at address p-1.
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int ADDR_W  = $clog2(CAPACITY);
   localparam int CHILD_W = CNT_W + 1;

   // Sequencer codes.
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_UP_CHK  = 3'd1;
   localparam logic [2:0] S_UP_CMP  = 3'd2;
   localparam logic [2:0] S_DN_LOAD = 3'd3;
   localparam logic [2:0] S_DN_CHK  = 3'd4;
   localparam logic [2:0] S_DN_SEL  = 3'd5;
   localparam logic [2:0] S_DN_CMP  = 3'd6;
   localparam logic [2:0] S_FINISH  = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] pos_ff, pos_in;       // hole being moved up or down
   value_type        val_ff, val_in;       // value looking for its place
   value_type        big_ff, big_in;       // larger child of the hole
   logic [CNT_W-1:0] big_pos_ff, big_pos_in;
   value_type        top_ff;               // mirror of the entry at the root
   status_type       status_ff, status_in;
   value_type        removed_ff, removed_in;

   logic             rsp_valid_ff;
   status_type       rsp_status_ff;
   value_type        rsp_removed_ff;
   value_type        rsp_top_ff;
   logic [CNT_W-1:0] rsp_count_ff;

   // Storage port signals.
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   value_type         wr_data;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;
   logic [31:0]       rd_data_a;
   logic [31:0]       rd_data_b;

   // Shared comparator: cmp_lt is true when cmp_a is strictly below cmp_b.
   value_type cmp_a;
   value_type cmp_b;
   logic      cmp_lt;

   // Derived positions.
   logic [CHILD_W-1:0] left_pos;
   logic [CHILD_W-1:0] right_pos;
   logic [CNT_W-1:0]   parent_pos;
   logic               load_rsp;
   logic               req_take;

   assign left_pos   = {pos_ff, 1'b0};
   assign right_pos  = left_pos + CHILD_W'(1);
   assign parent_pos = pos_ff >> 1;
   assign req_take   = req_chan.valid && req_chan.ready;
   assign load_rsp   = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   assign cmp_lt = cmp_a < cmp_b;

   bmhq_ram #(
      .WIDTH (32),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Operand selection for the comparator.
   always_comb begin
      case (state_ff)
         S_UP_CMP: begin
            // Parent strictly smaller than the climbing value?
            cmp_a = value_type'(rd_data_a);
            cmp_b = val_ff;
         end
         S_DN_SEL: begin
            // Left child strictly smaller than the right one?
            cmp_a = value_type'(rd_data_a);
            cmp_b = value_type'(rd_data_b);
         end
         default: begin
            // Sinking value strictly smaller than the larger child?
            cmp_a = val_ff;
            cmp_b = big_ff;
         end
      endcase
   end

   // Sequencer and storage control.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      big_in     = big_ff;
      big_pos_in = big_pos_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      wr_en      = 1'b0;
      wr_addr    = ADDR_W'(pos_ff - CNT_W'(1));
      wr_data    = val_ff;
      rd_addr_a  = ADDR_W'(left_pos - CHILD_W'(1));
      rd_addr_b  = ADDR_W'(left_pos);

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               status_in  = ST_DONE;
               removed_in = '0;
               if (req_chan.opcode == OP_INSERT) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     status_in = ST_FULL;
                     state_in  = S_FINISH;
                  end else begin
                     // The new value starts in the slot after the last entry.
                     count_in = count_ff + CNT_W'(1);
                     pos_in   = count_ff + CNT_W'(1);
                     val_in   = req_chan.value;
                     state_in = S_UP_CHK;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_FINISH;
                  end else begin
                     removed_in = top_ff;
                     count_in   = count_ff - CNT_W'(1);
                     if (count_ff == CNT_W'(1)) begin
                        state_in = S_FINISH;
                     end else begin
                        // Fetch the last entry; it restarts from the root.
                        rd_addr_a = ADDR_W'(count_ff - CNT_W'(1));
                        state_in  = S_DN_LOAD;
                     end
                  end
               end
            end
         end

         S_UP_CHK: begin
            if (pos_ff == CNT_W'(1)) begin
               wr_en    = 1'b1;
               state_in = S_FINISH;
            end else begin
               rd_addr_a = ADDR_W'(parent_pos - CNT_W'(1));
               state_in  = S_UP_CMP;
            end
         end

         S_UP_CMP: begin
            wr_en = 1'b1;
            if (cmp_lt) begin
               // Parent moves down into the hole; the hole climbs.
               wr_data  = value_type'(rd_data_a);
               pos_in   = parent_pos;
               state_in = S_UP_CHK;
            end else begin
               state_in = S_FINISH;
            end
         end

         S_DN_LOAD: begin
            val_in   = value_type'(rd_data_a);
            pos_in   = CNT_W'(1);
            state_in = S_DN_CHK;
         end

         S_DN_CHK: begin
            if (left_pos > CHILD_W'(count_ff)) begin
               wr_en    = 1'b1;
               state_in = S_FINISH;
            end else begin
               state_in = S_DN_SEL;
            end
         end

         S_DN_SEL: begin
            // The right child only counts when it lies within the heap;
            // on a tie the left child is kept.
            if (right_pos <= CHILD_W'(count_ff) && cmp_lt) begin
               big_in     = value_type'(rd_data_b);
               big_pos_in = CNT_W'(right_pos);
            end else begin
               big_in     = value_type'(rd_data_a);
               big_pos_in = CNT_W'(left_pos);
            end
            state_in = S_DN_CMP;
         end

         S_DN_CMP: begin
            wr_en = 1'b1;
            if (cmp_lt) begin
               // Larger child moves up into the hole; the hole sinks.
               wr_data  = big_ff;
               pos_in   = big_pos_ff;
               state_in = S_DN_CHK;
            end else begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      big_ff     <= big_in;
      big_pos_ff <= big_pos_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      // Every write to the root is mirrored so the maximum is always at hand.
      if (wr_en && wr_addr == '0) begin
         top_ff <= wr_data;
      end
      if (load_rsp) begin
         rsp_status_ff  <= status_ff;
         rsp_removed_ff <= removed_ff;
         rsp_top_ff     <= (count_ff == '0) ? value_type'(0) : top_ff;
         rsp_count_ff   <= count_ff;
      end
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.removed_value = rsp_removed_ff;
   assign rsp_chan.top_value     = rsp_top_ff;
   assign rsp_chan.entry_count   = rsp_count_ff;

endmodule

/* sv/bmhq_checker.sv */
// -----------------------------------------------------------------------------
// bmhq_checker: port-level checks for the heap queue
// Watches the response channel and checks the flagged cases, the top value of an empty heap and the hold rule.
// -----------------------------------------------------------------------------
module bmhq_checker #(
   parameter int CAPACITY = 1024
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input bmhq_pkg::status_type             rsp_status,
   input bmhq_pkg::value_type              rsp_removed_value,
   input bmhq_pkg::value_type              rsp_top_value,
   input logic [$clog2(CAPACITY+1)-1:0]    rsp_entry_count
);
   import bmhq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // A delete on an empty heap reports all zeros.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |->
         rsp_removed_value == '0 && rsp_top_value == '0 && rsp_entry_count == '0)
      else $error("empty delete did not report zeros");

   // An insert is refused only when the heap is full.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |->
         rsp_entry_count == CNT_W'(CAPACITY) && rsp_removed_value == '0)
      else $error("full status with wrong count");

   // An empty heap has no maximum to show.
   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_count == '0 |-> rsp_top_value == '0)
      else $error("nonzero top on an empty heap");

   // A stalled transaction holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_removed_value) && $stable(rsp_top_value) &&
         $stable(rsp_entry_count))
      else $error("response changed while stalled");

endmodule

bind binary_max_heap_queue bmhq_checker #(
   .CAPACITY (CAPACITY)
) u_bmhq_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_removed_value (rsp_chan.removed_value),
   .rsp_top_value     (rsp_chan.top_value),
   .rsp_entry_count   (rsp_chan.entry_count)
);
